>>> rtl/wrmc_pkg.sv
// Shared types, constants and codes of the window range motion classifier.
package wrmc_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;

  localparam int DIST_W  = 16;
  localparam int TS_W    = 32;
  localparam int CLASS_W = 2;
  localparam int THR_W   = 16;
  localparam int MULT_W  = 4;
  localparam int CONF_W  = 8;
  localparam int GTHR_W  = THR_W + MULT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROSS_MULTIPLIER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_SAMPLES  = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd160;
  localparam logic [MULT_W-1:0] MULT_RESET = 4'd3;
  localparam logic [CONF_W-1:0] CONF_RESET = 8'd3;

  localparam logic [CLASS_W-1:0] CLASS_STATIC = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MICRO  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_GROSS  = 2'd2;

  localparam logic [CONF_W-1:0] AGREE_MAX = 8'd255;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 104;

  localparam int OUT_DIST_LSB    = 0;
  localparam int OUT_RANGE_LSB   = 16;
  localparam int OUT_CLASS_LSB   = 32;
  localparam int OUT_CHANGED_BIT = 34;
  localparam int OUT_AGE_LSB     = 35;
  localparam int OUT_ALERT_LSB   = 67;
  localparam int OUT_PAD_W       = 5;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

endpackage

>>> rtl/wrmc_cell.sv
// One window cell: a stored distance with its valid bit, shifted to the next cell.
module wrmc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift_en,
  input  logic [wrmc_pkg::DIST_W-1:0] d_val,
  input  logic                        d_vld,
  output logic [wrmc_pkg::DIST_W-1:0] q_val,
  output logic                        q_vld
);

  logic [wrmc_pkg::DIST_W-1:0] val_r;
  logic                        vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= d_val;
    end
  end

  assign q_val = val_r;
  assign q_vld = vld_r;

endmodule

>>> rtl/wrmc_scan.sv
// Scan unit at the end of the cell chain: running min, max and largest jump.
module wrmc_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wrmc_pkg::scan_ctl_t         ctl,
  input  logic [wrmc_pkg::DIST_W-1:0] val,
  input  logic                        vld,
  output logic [wrmc_pkg::DIST_W-1:0] range,
  output logic [wrmc_pkg::DIST_W-1:0] jump
);

  logic                        first_r;
  logic [wrmc_pkg::DIST_W-1:0] lo_r;
  logic [wrmc_pkg::DIST_W-1:0] hi_r;
  logic [wrmc_pkg::DIST_W-1:0] jump_r;
  logic [wrmc_pkg::DIST_W-1:0] prev_r;
  logic [wrmc_pkg::DIST_W-1:0] diff;

  assign diff = (val > prev_r) ? (val - prev_r) : (prev_r - val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (ctl.start) begin
      first_r <= 1'b1;
    end else if (ctl.step && vld) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && vld) begin
      prev_r <= val;
      if (first_r) begin
        lo_r   <= val;
        hi_r   <= val;
        jump_r <= '0;
      end else begin
        if (val < lo_r) begin
          lo_r <= val;
        end
        if (val > hi_r) begin
          hi_r <= val;
        end
        if (diff > jump_r) begin
          jump_r <= diff;
        end
      end
    end
  end

  assign range = hi_r - lo_r;
  assign jump  = jump_r;

endmodule

>>> rtl/window_range_motion_classifier.sv
// Top level of the window range motion classifier: cell chain, scan and class logic.
//
//  Channel  Direction  Handshake                 Payload
//  in_      input      in_tvalid / in_tready     tuser sample_ok, tdata distance, timestamp
//  out_     output     out_tvalid / out_tready   tuser result_ok, tdata result fields
//  cfg_     input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A valid item is shifted into the chain, the chain makes one full rotation past the scan
// unit, and the item is classified. An invalid item goes straight to classification. The
// result waits in an output register, so the next item is taken meanwhile; only
// classification stalls while the output register is full and not taken.
// Reset clears the window valid bits, the class state and the registers to their defaults.
module window_range_motion_classifier #(
  parameter int WINDOW_DEPTH = wrmc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Bits from the lowest: distance[15:0], timestamp[47:16].
  input  logic [wrmc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Bit 0: sample_ok.
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Bits from the lowest: distance_out[15:0], motion_range[31:16], motion_class[33:32],
  // class_changed[34], state_age[66:35], last_alert_time[98:67], zero fill[103:99].
  output logic [wrmc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Bit 0: result_ok.
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wrmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wrmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLASS = 2'd2;

  logic [1:0]       state_r;
  logic [CNT_W-1:0] cnt_r;

  logic [wrmc_pkg::THR_W-1:0]  thr_r;
  logic [wrmc_pkg::MULT_W-1:0] mult_r;
  logic [wrmc_pkg::CONF_W-1:0] conf_r;

  logic                         ok_r;
  logic [wrmc_pkg::DIST_W-1:0]  dist_r;
  logic [wrmc_pkg::TS_W-1:0]    ts_r;

  logic [wrmc_pkg::CLASS_W-1:0] cur_class_r;
  logic [wrmc_pkg::CLASS_W-1:0] cand_class_r;
  logic [wrmc_pkg::CONF_W-1:0]  agree_r;
  logic [wrmc_pkg::TS_W-1:0]    trans_time_r;
  logic [wrmc_pkg::TS_W-1:0]    alert_time_r;
  logic [wrmc_pkg::DIST_W-1:0]  held_range_r;

  logic                             out_valid_r;
  logic [wrmc_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                             out_tuser_r;

  logic in_acc;
  logic insert;
  logic scanning;
  logic slot_free;
  logic class_fire;

  logic [wrmc_pkg::DIST_W-1:0] cell_val [WINDOW_DEPTH];
  logic                        cell_vld [WINDOW_DEPTH];

  wrmc_pkg::scan_ctl_t         scan_ctl;
  logic [wrmc_pkg::DIST_W-1:0] scan_range;
  logic [wrmc_pkg::DIST_W-1:0] scan_jump;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign insert     = in_acc && in_tuser;
  assign scanning   = (state_r == ST_SCAN);
  assign slot_free  = !out_valid_r || out_tready;
  assign class_fire = (state_r == ST_CLASS) && slot_free;
  assign cfg_ready  = 1'b1;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      wrmc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (insert || scanning),
        .d_val    (insert ? in_tdata[wrmc_pkg::DIST_W-1:0] : cell_val[WINDOW_DEPTH-1]),
        .d_vld    (insert ? 1'b1 : cell_vld[WINDOW_DEPTH-1]),
        .q_val    (cell_val[k]),
        .q_vld    (cell_vld[k])
      );
    end else begin : g_body
      wrmc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (insert || scanning),
        .d_val    (cell_val[k-1]),
        .d_vld    (cell_vld[k-1]),
        .q_val    (cell_val[k]),
        .q_vld    (cell_vld[k])
      );
    end
  end

  assign scan_ctl.start = insert;
  assign scan_ctl.step  = scanning;

  wrmc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .val   (cell_val[WINDOW_DEPTH-1]),
    .vld   (cell_vld[WINDOW_DEPTH-1]),
    .range (scan_range),
    .jump  (scan_jump)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= wrmc_pkg::THR_RESET;
      mult_r <= wrmc_pkg::MULT_RESET;
      conf_r <= wrmc_pkg::CONF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wrmc_pkg::REG_MOTION_THRESHOLD: thr_r  <= cfg_data;
        wrmc_pkg::REG_GROSS_MULTIPLIER: mult_r <= cfg_data[wrmc_pkg::MULT_W-1:0];
        wrmc_pkg::REG_CONFIRM_SAMPLES:  conf_r <= cfg_data[wrmc_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [wrmc_pkg::GTHR_W-1:0]  gross_thr;
  logic [wrmc_pkg::CLASS_W-1:0] next_class;
  logic [wrmc_pkg::CONF_W-1:0]  agree_nxt;
  logic [wrmc_pkg::CLASS_W-1:0] cand_nxt;
  logic [wrmc_pkg::CLASS_W-1:0] cur_nxt;
  logic [wrmc_pkg::TS_W-1:0]    trans_nxt;
  logic [wrmc_pkg::TS_W-1:0]    alert_nxt;
  logic [wrmc_pkg::DIST_W-1:0]  range_nxt;
  logic                         changed;

  assign gross_thr = wrmc_pkg::GTHR_W'(thr_r) * wrmc_pkg::GTHR_W'(mult_r);

  always_comb begin
    next_class = wrmc_pkg::CLASS_STATIC;
    if ((wrmc_pkg::GTHR_W'(scan_range) >= gross_thr) ||
        (wrmc_pkg::GTHR_W'(scan_jump) >= gross_thr)) begin
      next_class = wrmc_pkg::CLASS_GROSS;
    end else if (scan_range >= thr_r) begin
      next_class = wrmc_pkg::CLASS_MICRO;
    end
  end

  always_comb begin
    agree_nxt = agree_r;
    cand_nxt  = cand_class_r;
    cur_nxt   = cur_class_r;
    trans_nxt = trans_time_r;
    alert_nxt = alert_time_r;
    range_nxt = held_range_r;
    changed   = 1'b0;
    if (ok_r) begin
      range_nxt = scan_range;
      if (next_class != cur_class_r) begin
        if (next_class == cand_class_r) begin
          if (agree_r != wrmc_pkg::AGREE_MAX) begin
            agree_nxt = agree_r + 1'b1;
          end
        end else begin
          cand_nxt  = next_class;
          agree_nxt = wrmc_pkg::CONF_W'(1);
        end
        if (agree_nxt >= conf_r) begin
          cur_nxt   = next_class;
          trans_nxt = ts_r;
          if (next_class != wrmc_pkg::CLASS_STATIC) begin
            alert_nxt = ts_r;
          end
          agree_nxt = '0;
          changed   = 1'b1;
        end
      end else begin
        agree_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      cur_class_r  <= wrmc_pkg::CLASS_STATIC;
      cand_class_r <= wrmc_pkg::CLASS_STATIC;
      agree_r      <= '0;
      trans_time_r <= '0;
      alert_time_r <= '0;
      held_range_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (class_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_acc) begin
            state_r <= in_tuser ? ST_SCAN : ST_CLASS;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (slot_free) begin
            cur_class_r  <= cur_nxt;
            cand_class_r <= cand_nxt;
            agree_r      <= agree_nxt;
            trans_time_r <= trans_nxt;
            alert_time_r <= alert_nxt;
            held_range_r <= range_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok_r   <= in_tuser;
      dist_r <= in_tdata[wrmc_pkg::DIST_W-1:0];
      ts_r   <= in_tdata[wrmc_pkg::DIST_W +: wrmc_pkg::TS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (class_fire) begin
      out_tuser_r <= ok_r;
      out_tdata_r <= {
        {wrmc_pkg::OUT_PAD_W{1'b0}},
        alert_nxt,
        ts_r - trans_nxt,
        changed,
        cur_nxt,
        range_nxt,
        ok_r ? dist_r : {wrmc_pkg::DIST_W{1'b0}}
      };
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> rtl/wrmc_checker.sv
// Port checker of the window range motion classifier and its bind to the top level.
module wrmc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wrmc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result item changed while stalled.");

  a_invalid_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[wrmc_pkg::OUT_DIST_LSB +: wrmc_pkg::DIST_W] == '0)
    else $error("Invalid result item carries a nonzero distance.");

  a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[wrmc_pkg::OUT_CLASS_LSB +: wrmc_pkg::CLASS_W] != 2'd3)
    else $error("Result item carries an undefined class.");

  a_change_age_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[wrmc_pkg::OUT_CHANGED_BIT] |->
      out_tdata[wrmc_pkg::OUT_AGE_LSB +: wrmc_pkg::TS_W] == '0)
    else $error("Class change reported with a nonzero state age.");

  a_change_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[wrmc_pkg::OUT_CHANGED_BIT] |-> out_tuser)
    else $error("Class change reported on an invalid item.");

endmodule

bind window_range_motion_classifier wrmc_checker u_wrmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
